// ===== hw/rtl/angle_speed_tracking_observer_macros.svh =====
// Assertion macros shared by the angle and speed tracking observer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ANGLE_SPEED_TRACKING_OBSERVER_MACROS_SVH
`define ANGLE_SPEED_TRACKING_OBSERVER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASTO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ASTO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/asto_pkg.sv =====
// Package for the angle and speed tracking observer: constants, beat and
// microcode types, and the operation dispatch function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package asto_pkg;

    // Angle resolution kept in every stored or reported angle.
    localparam int ANGLE_BITS = 32;
    localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

    // Prediction age saturates here.
    localparam logic [15:0] AGE_LIMIT = 16'hFFFF;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_PREDICT = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GAIN_POS   = 3'd0;
    localparam logic [2:0] CFG_GAIN_SPEED = 3'd1;
    localparam logic [2:0] CFG_DELAY      = 3'd2;
    localparam logic [2:0] CFG_POLE_PAIRS = 3'd3;
    localparam logic [2:0] CFG_OFFSET     = 3'd4;

    // Microprogram addresses.
    typedef logic [3:0] t_step;
    localparam t_step STEP_UPD_DLY  = 4'd0;
    localparam t_step STEP_UPD_COMP = 4'd1;
    localparam t_step STEP_UPD_ERR  = 4'd2;
    localparam t_step STEP_UPD_GSPD = 4'd3;
    localparam t_step STEP_UPD_NS   = 4'd4;
    localparam t_step STEP_UPD_CHK  = 4'd5;
    localparam t_step STEP_UPD_CORR = 4'd6;
    localparam t_step STEP_UPD_OVF  = 4'd7;
    localparam t_step STEP_PREDICT  = 4'd8;
    localparam t_step STEP_SEED     = 4'd9;
    localparam t_step STEP_TAIL0    = 4'd10;
    localparam t_step STEP_TAIL1    = 4'd11;
    localparam t_step STEP_TAIL2    = 4'd12;
    localparam t_step STEP_LAST     = STEP_TAIL2;

    // Multiplier operand selects.
    typedef enum logic [2:0] {
        MA_NONE,
        MA_SPEED,
        MA_ERR,
        MA_EST_OFS,
        MA_PRED_OFS
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_NONE,
        MB_DELAY,
        MB_GSPD,
        MB_GPOS,
        MB_PP
    } t_mul_b;

    // Register write actions of the datapath.
    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_COMP,
        ALU_ERR,
        ALU_NS,
        ALU_CORRECT,
        ALU_SEED_ZERO,
        ALU_PREDICT,
        ALU_SEED,
        ALU_PRED_ANGLE,
        ALU_ELEC
    } t_alu;

    // Jump conditions.
    typedef enum logic [1:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_OVF
    } t_jmp;

    // One control word of the microprogram.
    typedef struct packed {
        t_mul_a mul_a;
        t_mul_b mul_b;
        t_alu   alu;
        t_jmp   jmp;
        t_step  target;
        logic   last;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic   accept;
        logic   exec;
        t_mul_a mul_a;
        t_mul_b mul_b;
        t_alu   alu;
        logic   load_out;
    } t_dp_ctl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic ovf;
    } t_dp_status;

    // Result payload held in the output register.
    typedef struct packed {
        logic [31:0] mech_angle;
        logic [31:0] elec_ang;
        logic [31:0] mech_speed;
        logic [31:0] mech_pred;
        logic [31:0] elec_pred;
        logic [15:0] prediction_age;
        logic        tracking_reset;
    } t_out_beat;

    // Sequencer state.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Entry point of the microprogram for an operation code.
    function automatic t_step op_entry(input logic [1:0] op);
        t_step s;
        unique case (op)
            OP_UPDATE:  s = STEP_UPD_DLY;
            OP_PREDICT: s = STEP_PREDICT;
            OP_RESET:   s = STEP_SEED;
            default:    s = STEP_TAIL0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asto_in_if.sv =====
// Input channel of the tracking observer: valid, ready and the input beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface asto_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [31:0]        angle_in;
    logic signed [31:0] seed_speed;

    modport source (output valid, output operation, output angle_in, output seed_speed,
                    input ready);
    modport sink (input valid, input operation, input angle_in, input seed_speed,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/asto_out_if.sv =====
// Result channel of the tracking observer: valid, ready and the result beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface asto_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        mech_angle;
    logic [31:0]        elec_ang;
    logic signed [31:0] mech_speed;
    logic [31:0]        mech_pred;
    logic [31:0]        elec_pred;
    logic [15:0]        prediction_age;
    logic               tracking_reset;

    modport source (output valid, output mech_angle, output elec_ang, output mech_speed,
                    output mech_pred, output elec_pred,
                    output prediction_age, output tracking_reset, input ready);
    modport sink (input valid, input mech_angle, input elec_ang, input mech_speed,
                  input mech_pred, input elec_pred,
                  input prediction_age, input tracking_reset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/angle_speed_tracking_observer.sv =====
// Top level of the alpha-beta angle and speed tracking observer.
// Depends on asto_pkg, asto_in_if, asto_out_if, asto_ucode_rom,
// asto_sequencer and asto_datapath.
//
//   channel   direction  handshake      beat contents
//   i_in      in         valid/ready    operation, angle_in, seed_speed
//   o_out     out        valid/ready    angles, speed, predictions, age, flag
//   i_cfg_*   in         write enable   register index and data, no read-back
//
// An input beat is taken only while the sequencer is idle; one beat is worked
// at a time by the microprogram around the single shared 33x25 multiplier.
// Update runs more steps than predict and reset, an unused operation code
// only the common tail; the result is valid in the cycle after the last step.
// A waiting result does not block the next accept; only the final step waits
// for the output register. Reset clears control, state and configuration.
`timescale 1ns / 1ps
`default_nettype none

module angle_speed_tracking_observer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    asto_in_if.sink     i_in,
    asto_out_if.source  o_out
);
    import asto_pkg::*;

    t_step      w_step;
    t_uword     w_uword;
    t_dp_ctl    w_ctl;
    t_dp_status w_status;
    t_out_beat  w_out;

    // Microprogram store.
    asto_ucode_rom u_rom (
        .i_step  (w_step),
        .o_uword (w_uword)
    );

    // Step counter and handshakes.
    asto_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_uword     (w_uword),
        .o_step      (w_step),
        .o_ctl       (w_ctl),
        .i_status    (w_status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready)
    );

    // Arithmetic, state and output register.
    asto_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_angle_in   (i_in.angle_in),
        .i_seed_speed (i_in.seed_speed),
        .i_ctl        (w_ctl),
        .o_status     (w_status),
        .o_out        (w_out)
    );

    // Result beat onto the channel.
    assign o_out.mech_angle     = w_out.mech_angle;
    assign o_out.elec_ang       = w_out.elec_ang;
    assign o_out.mech_speed     = w_out.mech_speed;
    assign o_out.mech_pred      = w_out.mech_pred;
    assign o_out.elec_pred      = w_out.elec_pred;
    assign o_out.prediction_age = w_out.prediction_age;
    assign o_out.tracking_reset = w_out.tracking_reset;

endmodule

`default_nettype wire

// ===== hw/rtl/asto_ucode_rom.sv =====
// Microprogram of the tracking observer: one control word per step address.
// Depends on asto_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asto_ucode_rom (
    input  asto_pkg::t_step  i_step,
    output asto_pkg::t_uword o_uword
);
    import asto_pkg::*;

    // Update runs delay compensation, error, speed and position correction;
    // every path ends in the common tail that forms the electrical angles.
    always_comb begin
        unique case (i_step)
            STEP_UPD_DLY:  o_uword = '{MA_SPEED,    MB_DELAY, ALU_NONE,
                                      JMP_NEVER,  STEP_UPD_DLY, 1'b0};
            STEP_UPD_COMP: o_uword = '{MA_NONE,     MB_NONE,  ALU_COMP,
                                      JMP_NEVER,  STEP_UPD_DLY, 1'b0};
            STEP_UPD_ERR:  o_uword = '{MA_NONE,     MB_NONE,  ALU_ERR,
                                      JMP_NEVER,  STEP_UPD_DLY, 1'b0};
            STEP_UPD_GSPD: o_uword = '{MA_ERR,      MB_GSPD,  ALU_NONE,
                                      JMP_NEVER,  STEP_UPD_DLY, 1'b0};
            STEP_UPD_NS:   o_uword = '{MA_ERR,      MB_GPOS,  ALU_NS,
                                      JMP_NEVER,  STEP_UPD_DLY, 1'b0};
            STEP_UPD_CHK:  o_uword = '{MA_NONE,     MB_NONE,  ALU_NONE,
                                      JMP_OVF,    STEP_UPD_OVF, 1'b0};
            STEP_UPD_CORR: o_uword = '{MA_NONE,     MB_NONE,  ALU_CORRECT,
                                      JMP_ALWAYS, STEP_TAIL0, 1'b0};
            STEP_UPD_OVF:  o_uword = '{MA_NONE,     MB_NONE,  ALU_SEED_ZERO,
                                      JMP_ALWAYS, STEP_TAIL0, 1'b0};
            STEP_PREDICT:  o_uword = '{MA_NONE,     MB_NONE,  ALU_PREDICT,
                                      JMP_ALWAYS, STEP_TAIL0, 1'b0};
            STEP_SEED:     o_uword = '{MA_NONE,     MB_NONE,  ALU_SEED,
                                      JMP_ALWAYS, STEP_TAIL0, 1'b0};
            STEP_TAIL0:    o_uword = '{MA_EST_OFS,  MB_PP,    ALU_PRED_ANGLE,
                                      JMP_NEVER,  STEP_TAIL0, 1'b0};
            STEP_TAIL1:    o_uword = '{MA_PRED_OFS, MB_PP,    ALU_ELEC,
                                      JMP_NEVER,  STEP_TAIL0, 1'b0};
            STEP_TAIL2:    o_uword = '{MA_NONE,     MB_NONE,  ALU_NONE,
                                      JMP_NEVER,  STEP_TAIL0, 1'b1};
            default:       o_uword = '{MA_NONE,     MB_NONE,  ALU_NONE,
                                      JMP_NEVER,  STEP_TAIL0, 1'b1};
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/asto_sequencer.sv =====
// Step counter, jump logic and handshake control of the tracking observer.
// Depends on asto_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_speed_tracking_observer_macros.svh"

module asto_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_in_op,
    output logic                 o_in_ready,
    input  asto_pkg::t_uword     i_uword,
    output asto_pkg::t_step      o_step,
    output asto_pkg::t_dp_ctl    o_ctl,
    input  asto_pkg::t_dp_status i_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);
    import asto_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    t_step      r_step;
    t_step      n_step;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_stall;
    logic       w_taken;

    // The last step waits while the output register still holds a beat.
    assign w_stall  = (r_state == SEQ_RUN) && i_uword.last && r_out_valid && !i_out_ready;
    assign w_accept = i_in_valid && (r_state == SEQ_IDLE);

    // Jump decision of the current control word.
    always_comb begin
        unique case (i_uword.jmp)
            JMP_NEVER:  w_taken = 1'b0;
            JMP_ALWAYS: w_taken = 1'b1;
            JMP_OVF:    w_taken = i_status.ovf;
            default:    w_taken = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (i_uword.last && !w_stall) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl.accept   = w_accept;
        o_ctl.exec     = 1'b0;
        o_ctl.mul_a    = i_uword.mul_a;
        o_ctl.mul_b    = i_uword.mul_b;
        o_ctl.alu      = i_uword.alu;
        o_ctl.load_out = 1'b0;
        unique case (r_state)
            SEQ_IDLE: begin
                o_in_ready = 1'b1;
            end
            SEQ_RUN: begin
                o_ctl.exec     = !w_stall;
                o_ctl.load_out = i_uword.last && !w_stall;
            end
            default: ;
        endcase
    end

    // Step counter: dispatch on accept, then step or jump.
    always_comb begin
        n_step = r_step;
        if (w_accept) begin
            n_step = op_entry(i_in_op);
        end else if (o_ctl.exec && !i_uword.last) begin
            n_step = w_taken ? i_uword.target : t_step'(r_step + 4'd1);
        end
    end

    // Output valid is set by a load and cleared when the beat is taken.
    assign n_out_valid = o_ctl.load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_step      <= STEP_UPD_DLY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_step      = r_step;
    assign o_out_valid = r_out_valid;

    // The output register is only overwritten once its beat has gone.
    `ASTO_ASSERT_IMP(a_load_has_room, i_clk, i_rst_n, o_ctl.load_out, !r_out_valid || i_out_ready, "output beat overwritten")
    // An accepted beat always starts the microprogram.
    `ASTO_ASSERT_NXT(a_accept_runs, i_clk, i_rst_n, w_accept, r_state == SEQ_RUN, "accept did not start a run")
    // The step counter never leaves the microprogram.
    `ASTO_ASSERT_IMP(a_step_in_rom, i_clk, i_rst_n, r_state == SEQ_RUN, r_step <= STEP_LAST, "step outside microprogram")
    // A stalled final step holds its address.
    `ASTO_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, w_stall, $stable(r_step) && r_state == SEQ_RUN, "stalled step moved")

endmodule

`default_nettype wire

// ===== hw/rtl/asto_datapath.sv =====
// Datapath of the tracking observer: configuration registers, tracker state,
// shared multiplier, scratch registers and the output register.
// Depends on asto_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asto_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic [31:0]          i_angle_in,
    input  logic [31:0]          i_seed_speed,
    input  asto_pkg::t_dp_ctl    i_ctl,
    output asto_pkg::t_dp_status o_status,
    output asto_pkg::t_out_beat  o_out
);
    import asto_pkg::*;

    // Configuration.
    logic [17:0] r_gpos;
    logic [23:0] r_gspd;
    logic [15:0] r_delay;
    logic [7:0]  r_pp;
    logic [31:0] r_ofs;

    // Tracker state.
    logic [31:0] r_est;
    logic [31:0] r_spd;
    logic [15:0] r_age;
    logic        r_flag;

    // Operands of the beat in progress and scratch registers.
    logic [31:0]        r_ang;
    logic [31:0]        r_sspd;
    logic [31:0]        r_comp;
    logic [32:0]        r_err;
    logic [33:0]        r_ns;
    logic [31:0]        r_pred;
    logic [31:0]        r_elec;
    logic signed [57:0] r_prod;
    t_out_beat          r_out;

    logic signed [32:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [57:0] w_prod;
    logic [7:0]         w_pp;
    logic [31:0]        w_diff;

    // Zero pole pairs behaves as one.
    assign w_pp = (r_pp == 8'd0) ? 8'd1 : r_pp;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpos  <= '0;
            r_gspd  <= '0;
            r_delay <= '0;
            r_pp    <= 8'd1;
            r_ofs   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_POS:   r_gpos  <= i_cfg_data[17:0];
                CFG_GAIN_SPEED: r_gspd  <= i_cfg_data[23:0];
                CFG_DELAY:      r_delay <= i_cfg_data[15:0];
                CFG_POLE_PAIRS: r_pp    <= i_cfg_data[7:0];
                CFG_OFFSET:     r_ofs   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared signed multiplier operands.
    always_comb begin
        unique case (i_ctl.mul_a)
            MA_SPEED:    w_mul_a = {r_spd[31], r_spd};
            MA_ERR:      w_mul_a = r_err;
            MA_EST_OFS:  w_mul_a = {1'b0, r_est + r_ofs};
            MA_PRED_OFS: w_mul_a = {1'b0, r_pred + r_ofs};
            default:     w_mul_a = '0;
        endcase
        unique case (i_ctl.mul_b)
            MB_DELAY: w_mul_b = {9'd0, r_delay};
            MB_GSPD:  w_mul_b = {1'b0, r_gspd};
            MB_GPOS:  w_mul_b = {7'd0, r_gpos};
            MB_PP:    w_mul_b = {17'd0, w_pp};
            default:  w_mul_b = '0;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Wrapped angle error; exactly half a turn counts as positive.
    assign w_diff = r_comp - r_est;

    // Overflow of the corrected speed out of the signed 32-bit range.
    assign o_status.ovf = (r_ns[33:31] != 3'b000) && (r_ns[33:31] != 3'b111);

    // Product register and scratch registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_ang  <= i_angle_in;
            r_sspd <= i_seed_speed;
        end
        if (i_ctl.exec && i_ctl.mul_a != MA_NONE) begin
            r_prod <= w_prod;
        end
        if (i_ctl.exec) begin
            unique case (i_ctl.alu)
                ALU_COMP:       r_comp <= r_ang + r_prod[39:8];
                ALU_ERR:        r_err  <= (w_diff == 32'h8000_0000) ? {1'b0, w_diff}
                                                                    : {w_diff[31], w_diff};
                ALU_NS:         r_ns   <= {{2{r_spd[31]}}, r_spd} + r_prod[57:24];
                ALU_PRED_ANGLE: r_pred <= (r_est + r_spd) & ANGLE_MASK;
                ALU_ELEC:       r_elec <= r_prod[31:0] & ANGLE_MASK;
                default: ;
            endcase
        end
    end

    // Tracker state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est  <= '0;
            r_spd  <= '0;
            r_age  <= '0;
            r_flag <= 1'b0;
        end else begin
            if (i_ctl.accept) begin
                r_flag <= 1'b0;
            end
            if (i_ctl.exec) begin
                unique case (i_ctl.alu)
                    ALU_CORRECT: begin
                        r_est <= (r_est + r_spd + r_prod[47:16]) & ANGLE_MASK;
                        r_spd <= r_ns[31:0];
                        r_age <= '0;
                    end
                    ALU_SEED_ZERO: begin
                        r_est  <= r_ang & ANGLE_MASK;
                        r_spd  <= '0;
                        r_age  <= '0;
                        r_flag <= 1'b1;
                    end
                    ALU_PREDICT: begin
                        r_est <= (r_est + r_spd) & ANGLE_MASK;
                        if (r_age < AGE_LIMIT) begin
                            r_age <= r_age + 16'd1;
                        end
                    end
                    ALU_SEED: begin
                        r_est <= r_ang & ANGLE_MASK;
                        r_spd <= r_sspd;
                        r_age <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Output register, loaded on the final step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out.mech_angle     <= r_est;
            r_out.elec_ang       <= r_elec;
            r_out.mech_speed     <= r_spd;
            r_out.mech_pred      <= r_pred;
            r_out.elec_pred      <= r_prod[31:0] & ANGLE_MASK;
            r_out.prediction_age <= r_age;
            r_out.tracking_reset <= r_flag;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the alpha-beta angle and speed tracking observer.
// Needs asto_pkg, asto_in_if, asto_out_if and the angle_speed_tracking_observer RTL.
// A bit-accurate tracker model predicts every result beat; a checker compares them.
`timescale 1ns / 1ps

module tb_top;
    import asto_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_LIMIT      = 1000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int SETTING_ITEMS  = 220;
    localparam int AGE_RUN        = 200;
    localparam int REPORT_LINES   = 40;

    // The one operation code that the block leaves unused.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -64'sd2147483648;
    localparam longint HALF_TURN = 64'sd2147483648;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    asto_in_if  in_if ();
    asto_out_if out_if ();

    angle_speed_tracking_observer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Tracker copy: estimate, age and register values.
    logic [31:0] trk_angle;
    logic [31:0] trk_speed;
    logic [15:0] trk_age;
    logic [17:0] cfg_gpos;
    logic [23:0] cfg_gspd;
    logic [15:0] cfg_delay;
    logic [7:0]  cfg_pp;
    logic [31:0] cfg_ofs;

    t_out_beat pending_results [$];

    int  mismatches      = 0;
    int  in_beats        = 0;
    int  out_beats       = 0;
    int  overflow_resets = 0;
    int  settings_used   = 0;
    int  burst_left      = 0;
    int  hold_left       = 0;
    int  stall_cycles    = 0;
    bit  tx_gaps_en      = 1'b1;
    bit  rx_stall_en     = 1'b1;

    always #(CLK_HALF) i_clk = ~i_clk;

    // Electrical angle of a mechanical angle; zero pole pairs count as one.
    function automatic logic [31:0] elec_of(input logic [31:0] mech);
        logic [31:0] pp;
        pp = (cfg_pp == 8'd0) ? 32'd1 : {24'd0, cfg_pp};
        return ((mech + cfg_ofs) * pp) & ANGLE_MASK;
    endfunction

    // Advances the tracker copy by one input beat and returns the result it gives.
    function automatic t_out_beat track_observe(input logic [1:0] op, input logic [31:0] ang,
                                                input logic [31:0] sspd);
        t_out_beat   r;
        longint      spd_l;
        longint      err;
        longint      new_spd;
        longint      gain;
        logic [31:0] comp;
        logic [31:0] diff;
        logic [31:0] corr;
        logic [31:0] mech;
        logic [31:0] pred;
        logic        ovf;
        ovf   = 1'b0;
        spd_l = longint'($signed(trk_speed));
        if (op == OP_UPDATE) begin
            // Delay compensation, then the shortest-path error.
            comp = ang;
            if (cfg_delay != 16'd0) begin
                gain = longint'(cfg_delay);
                comp = ang + 32'((gain * spd_l) >>> 8);
            end
            diff = comp - trk_angle;
            if (diff == 32'h8000_0000)
                err = HALF_TURN;
            else
                err = longint'($signed(diff));
            gain    = longint'(cfg_gspd);
            new_spd = spd_l + ((gain * err) >>> 24);
            if (new_spd > SPEED_MAX || new_spd < SPEED_MIN) begin
                // Speed overflow restarts tracking from the raw sample.
                trk_angle = ang & ANGLE_MASK;
                trk_speed = 32'd0;
                trk_age   = 16'd0;
                ovf       = 1'b1;
            end else begin
                gain      = longint'(cfg_gpos);
                corr      = 32'((gain * err) >>> 16);
                trk_angle = (trk_angle + trk_speed + corr) & ANGLE_MASK;
                trk_speed = new_spd[31:0];
                trk_age   = 16'd0;
            end
        end else if (op == OP_PREDICT) begin
            trk_angle = (trk_angle + trk_speed) & ANGLE_MASK;
            if (trk_age < AGE_LIMIT)
                trk_age = trk_age + 16'd1;
        end else if (op == OP_RESET) begin
            trk_angle = ang & ANGLE_MASK;
            trk_speed = sspd;
            trk_age   = 16'd0;
        end
        mech = trk_angle & ANGLE_MASK;
        pred = (mech + trk_speed) & ANGLE_MASK;
        r.mech_angle     = mech;
        r.elec_ang       = elec_of(mech);
        r.mech_speed     = trk_speed;
        r.mech_pred      = pred;
        r.elec_pred      = elec_of(pred);
        r.prediction_age = trk_age;
        r.tracking_reset = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < REPORT_LINES)
            $display("[%0t] mismatch on %s: got %h, expected %h (result beat %0d)",
                     $realtime, what, got, want, out_beats);
        mismatches++;
    endtask

    // Sends an input beat, after a random gap if gaps are on and the burst is spent.
    task automatic send_beat(input logic [1:0] op, input logic [31:0] ang,
                             input logic [31:0] sspd);
        int        gap;
        t_out_beat exp_r;
        if (tx_gaps_en && burst_left == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        in_if.valid      <= 1'b1;
        in_if.operation  <= op;
        in_if.angle_in   <= ang;
        in_if.seed_speed <= sspd;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        exp_r = track_observe(op, ang, sspd);
        if (exp_r.tracking_reset)
            overflow_resets++;
        pending_results.push_back(exp_r);
        in_beats++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    // Holds the sender back until every expected beat is back and the block is quiet.
    task automatic drain_results();
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five registers in index order; only called while the block is idle.
    task automatic program_config(input logic [31:0] gpos, input logic [31:0] gspd,
                                  input logic [31:0] dly, input logic [31:0] pp,
                                  input logic [31:0] ofs);
        logic [2:0]  idxs [5];
        logic [31:0] vals [5];
        idxs = '{CFG_GAIN_POS, CFG_GAIN_SPEED, CFG_DELAY, CFG_POLE_PAIRS, CFG_OFFSET};
        vals = '{gpos, gspd, dly, pp, ofs};
        for (int i = 0; i < 5; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_gpos  = gpos[17:0];
        cfg_gspd  = gspd[23:0];
        cfg_delay = dly[15:0];
        cfg_pp    = pp[7:0];
        cfg_ofs   = ofs;
        settings_used++;
    endtask

    // Operations under the register values left by reset.
    task automatic test_power_on_defaults();
        send_beat(OP_PREDICT, 32'h0, 32'h0);
        send_beat(OP_UPDATE, 32'h1234_5678, 32'h0);
        send_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_RESET, 32'hDEAD_BEEF, 32'h0001_0000);
        send_beat(OP_PREDICT, 32'h0, 32'h0);
        send_beat(OP_UPDATE, 32'hDEAE_BEEF, 32'h0);
    endtask

    // Field extremes, half-turn error, both overflow directions, zero pole pairs.
    task automatic test_directed_corners();
        drain_results();
        program_config(32'h0003_FFFF, 32'h00FF_FFFF, 32'h0000_FFFF, 32'h0000_00FF,
                       32'h7FFF_FFFF);
        send_beat(OP_RESET, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_PREDICT, 32'h0, 32'h0);
        send_beat(OP_UPDATE, 32'h0, 32'hFFFF_FFFF);
        send_beat(OP_RESET, 32'h0, 32'h8000_0000);
        send_beat(OP_UPDATE, 32'hFFFF_FFFF, 32'h0);
        // Zero speed keeps the delay term out of the half-turn error.
        send_beat(OP_RESET, 32'h0, 32'h0);
        send_beat(OP_UPDATE, 32'h8000_0000, 32'h0);
        drain_results();
        program_config(32'h0003_FFFF, 32'h00FF_FFFF, 32'h0, 32'h0, 32'h8000_0000);
        // Speed pushed past the positive and then the negative limit.
        send_beat(OP_RESET, 32'h1234_5678, 32'h7FFF_FFF0);
        send_beat(OP_UPDATE, 32'h5234_5678, 32'h0);
        send_beat(OP_RESET, 32'h0, 32'h8000_0010);
        send_beat(OP_UPDATE, 32'hC000_0000, 32'h0);
        send_beat(OP_RESET, 32'h0, 32'h0);
        send_beat(OP_UPDATE, 32'h8000_0000, 32'h0);
        send_beat(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_PREDICT, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure_fill();
        logic [1:0] rnd_op;
        drain_results();
        program_config(32'h0000_2000, 32'h0000_0400, 32'h0000_0200, 32'd4, $urandom);
        tx_gaps_en = 1'b0;
        rx_stall_en = 1'b0;
        send_beat(OP_RESET, $urandom, 32'h0010_0000);
        hold_left = LONG_HOLD;
        repeat (30) begin
            rnd_op = 2'($urandom_range(0, 3));
            send_beat(rnd_op, $urandom, $urandom);
        end
    endtask

    // Short bursts, each followed by a pause until every result is back.
    task automatic test_drain_pause();
        logic [1:0] rnd_op;
        tx_gaps_en = 1'b1;
        rx_stall_en = 1'b1;
        repeat (3) begin
            repeat ($urandom_range(5, 12)) begin
                rnd_op = 2'($urandom_range(0, 3));
                send_beat(rnd_op, $urandom, $signed($urandom) >>> 6);
            end
            drain_results();
        end
    endtask

    // Seeded tracks of noisy samples and predicts under several settings, plus noise.
    task automatic test_random_tracking();
        int          start_beats;
        int          setting_start;
        int          setting;
        int          steps;
        logic [31:0] k;
        logic [31:0] true_ang;
        logic [31:0] true_spd;
        logic [31:0] noise;
        logic [1:0]  rnd_op;
        start_beats = in_beats;
        setting = 0;
        while (in_beats - start_beats < RANDOM_ITEMS) begin
            drain_results();
            k = $urandom_range(1, 64);
            case (setting % 5)
                0: program_config(32'h0003_FFFF, 32'h00FF_FFFF, 32'h0000_FFFF, 32'h0000_00FF,
                                  32'h7FFF_FFFF);
                1: program_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
                2: program_config($urandom, $urandom, $urandom, $urandom, $urandom);
                default: program_config(k * 512, k * k * 256,
                                        ($urandom_range(0, 2) == 0) ? 32'd0 :
                                                                      $urandom_range(0, 1024),
                                        $urandom_range(1, 255), $urandom);
            endcase
            tx_gaps_en = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            setting_start = in_beats;
            while (in_beats - setting_start < SETTING_ITEMS &&
                   in_beats - start_beats < RANDOM_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // A stray beat with any code and any content.
                    rnd_op = 2'($urandom_range(0, 3));
                    send_beat(rnd_op, $urandom, $urandom);
                end else begin
                    true_ang = $urandom;
                    if ($urandom_range(0, 7) == 0)
                        true_spd = $urandom_range(0, 1) ?
                                   32'h7FFF_FFFF - $urandom_range(0, 32'h0010_0000) :
                                   32'h8000_0000 + $urandom_range(0, 32'h0010_0000);
                    else
                        true_spd = $signed($urandom) >>> $urandom_range(4, 30);
                    send_beat(OP_RESET, true_ang, true_spd);
                    steps = $urandom_range(4, 40);
                    repeat (steps) begin
                        true_ang = true_ang + true_spd;
                        if ($urandom_range(0, 19) == 0)
                            true_spd = true_spd + ($signed($urandom) >>> 12);
                        case ($urandom_range(0, 19))
                            0: send_beat(OP_UPDATE, $urandom, $urandom);
                            1, 2, 3, 4: send_beat(OP_PREDICT, $urandom, $urandom);
                            default: begin
                                noise = $signed($urandom) >>> $urandom_range(6, 31);
                                send_beat(OP_UPDATE, true_ang + noise, $urandom);
                            end
                        endcase
                    end
                end
            end
            setting++;
        end
    endtask

    // A long run of predicts in a row that counts the age up, then an update clears it.
    task automatic test_age_count();
        drain_results();
        program_config(32'h0000_4000, 32'h0000_1000, 32'h0000_0180, 32'd7, 32'h0123_4567);
        tx_gaps_en = 1'b0;
        rx_stall_en = 1'b0;
        send_beat(OP_RESET, $urandom, $signed($urandom) >>> 8);
        repeat (AGE_RUN) send_beat(OP_PREDICT, $urandom, $urandom);
        send_beat(OP_UPDATE, $urandom, $urandom);
        send_beat(OP_PREDICT, $urandom, $urandom);
    endtask

    // Receiver: long hold-off when asked, otherwise random ready and stall runs.
    initial begin
        int   run;
        logic level;
        out_if.ready = 1'b0;
        run = 0;
        level = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (!rx_stall_en) begin
                out_if.ready <= 1'b1;
            end else begin
                if (run == 0) begin
                    level = ~level;
                    run = level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run--;
                out_if.ready <= level;
            end
        end
    end

    // Checker: each result beat against the oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (out_if.valid && out_if.ready) begin
            out_beats++;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected", out_if.mech_angle, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.mech_angle !== want.mech_angle)
                    report_mismatch("mech_angle", out_if.mech_angle, want.mech_angle);
                if (out_if.elec_ang !== want.elec_ang)
                    report_mismatch("elec_ang", out_if.elec_ang, want.elec_ang);
                if (out_if.mech_speed !== want.mech_speed)
                    report_mismatch("mech_speed", out_if.mech_speed, want.mech_speed);
                if (out_if.mech_pred !== want.mech_pred)
                    report_mismatch("mech_pred", out_if.mech_pred, want.mech_pred);
                if (out_if.elec_pred !== want.elec_pred)
                    report_mismatch("elec_pred", out_if.elec_pred, want.elec_pred);
                if (out_if.prediction_age !== want.prediction_age)
                    report_mismatch("prediction_age", 32'(out_if.prediction_age),
                                    32'(want.prediction_age));
                if (out_if.tracking_reset !== want.tracking_reset)
                    report_mismatch("tracking_reset", 32'(out_if.tracking_reset),
                                    32'(want.tracking_reset));
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence.
    initial begin
        int waited;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_GAIN_POS;
        i_cfg_data       = 32'd0;
        in_if.valid      = 1'b0;
        in_if.operation  = OP_UPDATE;
        in_if.angle_in   = 32'd0;
        in_if.seed_speed = 32'sd0;
        trk_angle        = 32'd0;
        trk_speed        = 32'd0;
        trk_age          = 16'd0;
        cfg_gpos         = 18'd0;
        cfg_gspd         = 24'd0;
        cfg_delay        = 16'd0;
        cfg_pp           = 8'd1;
        cfg_ofs          = 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_directed_corners();
        test_backpressure_fill();
        test_drain_pause();
        test_random_tracking();
        test_age_count();

        // Wait for the last results, then let the block settle.
        release_input();
        waited = 0;
        while (pending_results.size() != 0 && waited < END_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("expected results never arrived", pending_results.size(), 32'h0);

        $display("Covered %0d input beats and %0d result beats over %0d register settings,",
                 in_beats, out_beats, settings_used);
        $display("with %0d speed-overflow restarts, a long output stall and a long predict run.",
                 overflow_resets);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/asto_pkg.sv
hw/rtl/asto_in_if.sv
hw/rtl/asto_out_if.sv
hw/rtl/asto_ucode_rom.sv
hw/rtl/asto_sequencer.sv
hw/rtl/asto_datapath.sv
hw/rtl/angle_speed_tracking_observer.sv
dv/tb_top.sv
